// ----- sv/exponential_deviate_generator_top_defines.svh -----
// Assertion macros shared by the exponential deviate generator RTL.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef EXPONENTIAL_DEVIATE_GENERATOR_TOP_DEFINES_SVH
`define EXPONENTIAL_DEVIATE_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define EDG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("edg assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define EDG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("edg assertion failed");

`endif

// ----- sv/edg_pkg.sv -----
// Shared constants, tables and types of the exponential deviate generator.
// No dependencies; imported by the interfaces and all modules.
package edg_pkg;

	localparam int WORD_W  = 32;
	localparam int DEV_W   = 37;
	localparam int USED_W  = 4;
	localparam int ONES_W  = 6;
	localparam int Q_COUNT = 12;
	localparam int K_FIRST = 2;

	// ln2 as a 0.32 binary fraction
	localparam logic [WORD_W-1:0] LN2_FIX = 32'hB17217F8;

	// Q[k] = sum over i=1..k of ln2^i / i!, in 0.32 format
	localparam logic [WORD_W-1:0] Q_TAB [Q_COUNT] = '{
		32'h00000000, 32'hB17217F8, 32'hEEF193F7, 32'hFD271862,
		32'hFF9D6DD0, 32'hFFF4CFD0, 32'hFFFEE819, 32'hFFFFE7FF,
		32'hFFFFFE2B, 32'hFFFFFFE0, 32'hFFFFFFFE, 32'hFFFFFFFF
	};

	// Scale request: deviate = whole*ln2 + floor(frac*ln2) + addend
	typedef struct packed {
		logic [ONES_W-1:0] whole;
		logic [WORD_W-1:0] frac;
		logic [WORD_W-1:0] addend;
		logic [USED_W-1:0] used;
	} edg_op_t;

endpackage

// ----- sv/edg_word_if.sv -----
// Handshake channel carrying one uniform word per request.
// Depends on edg_pkg for the word width.
interface edg_word_if import edg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] uniform_word;

	modport source (output valid, output uniform_word, input ready);
	modport sink (input valid, input uniform_word, output ready);
endinterface

// ----- sv/edg_dev_if.sv -----
// Handshake channel carrying one exponential deviate per request.
// Depends on edg_pkg for the field widths.
interface edg_dev_if import edg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DEV_W-1:0]  deviate;
	logic [USED_W-1:0] words_used;

	modport source (output valid, output deviate, output words_used, input ready);
	modport sink (input valid, input deviate, input words_used, output ready);
endinterface

// ----- sv/edg_front.sv -----
// Input register, Algorithm S sequencing and the scale request register.
// Depends on edg_pkg, edg_word_if and the assertion macro header.
`include "exponential_deviate_generator_top_defines.svh"

module edg_front import edg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	edg_word_if.sink    uniforms,
	input  logic        scale_ready,
	output logic        op_valid,
	output edg_op_t     op
);

	localparam logic [1:0] PH_FIRST = 2'd0;
	localparam logic [1:0] PH_MIN   = 2'd1;

	// Leading-ones count, 0..32
	function automatic logic [ONES_W-1:0] lead_ones(input logic [WORD_W-1:0] w);
		logic [ONES_W-1:0] n;
		logic              hit;
		n   = ONES_W'(WORD_W);
		hit = 1'b0;
		for (int i = 0; i < WORD_W; i++) begin
			if (!w[WORD_W-1-i] && !hit) begin
				n   = ONES_W'(i);
				hit = 1'b1;
			end
		end
		return n;
	endfunction

	logic [WORD_W-1:0] word_s1;
	logic              valid_s1;
	edg_op_t           op_s2;
	logic              valid_s2;

	logic [1:0]        phase_q;
	logic [ONES_W-1:0] ones_q;
	logic [USED_W-1:0] left_q;
	logic [WORD_W-1:0] min_q;
	logic [USED_W-1:0] taken_q;

	logic              s2_free;
	logic              fire;
	logic [ONES_W-1:0] lones;
	logic [ONES_W-1:0] shamt;
	logic [WORD_W-1:0] frac_u;
	logic              direct;
	logic [USED_W-1:0] k_sel;
	logic [WORD_W-1:0] min_nx;
	logic [USED_W-1:0] taken_nx;
	logic [USED_W-1:0] left_dec;
	logic              emit;
	edg_op_t           op_nx;

	assign s2_free        = !valid_s2 || scale_ready;
	assign fire           = valid_s1 && s2_free;
	assign uniforms.ready = !valid_s1 || s2_free;
	assign op_valid       = valid_s2;
	assign op             = op_s2;

	// First word: strip leading ones and the zero, test against ln2
	assign lones  = lead_ones(word_s1);
	assign shamt  = lones + 6'd1;
	assign frac_u = word_s1 << shamt;
	assign direct = frac_u < LN2_FIX;

	// Least k in 2..11 with u < Q[k], else 12
	always_comb begin
		k_sel = USED_W'(Q_COUNT);
		for (int i = Q_COUNT - 1; i >= K_FIRST; i--) begin
			if (frac_u < Q_TAB[i])
				k_sel = USED_W'(i);
		end
	end

	// Minimum collection
	assign min_nx   = (word_s1 < min_q) ? word_s1 : min_q;
	assign taken_nx = taken_q + 4'd1;
	assign left_dec = (left_q != '0) ? left_q - 4'd1 : '0;

	// Result selection for the scale stage
	always_comb begin
		if (phase_q == PH_MIN) begin
			emit         = (left_dec == '0);
			op_nx.whole  = ones_q;
			op_nx.frac   = min_nx;
			op_nx.addend = '0;
			op_nx.used   = taken_nx;
		end else begin
			emit         = direct;
			op_nx.whole  = lones;
			op_nx.frac   = '0;
			op_nx.addend = frac_u;
			op_nx.used   = 4'd1;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (uniforms.ready) begin
			valid_s1 <= uniforms.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (uniforms.ready && uniforms.valid)
			word_s1 <= uniforms.uniform_word;
	end

	// Deviate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			ones_q  <= '0;
			left_q  <= '0;
			min_q   <= '0;
			taken_q <= '0;
		end else if (fire) begin
			if (phase_q == PH_MIN) begin
				min_q   <= min_nx;
				taken_q <= taken_nx;
				left_q  <= left_dec;
				if (left_dec == '0)
					phase_q <= PH_FIRST;
			end else if (!direct) begin
				phase_q <= PH_MIN;
				ones_q  <= lones;
				left_q  <= k_sel;
				min_q   <= '1;
				taken_q <= 4'd1;
			end else begin
				phase_q <= PH_FIRST;
			end
		end
	end

	// Scale request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && fire && emit)
			op_s2 <= op_nx;
	end

	// While collecting, at least one word is still owed
	`EDG_ASSERT_NOW(a_left_nonzero, phase_q == PH_MIN, left_q != '0)
	// Words taken plus words owed never pass thirteen
	`EDG_ASSERT_NOW(a_budget, phase_q == PH_MIN,
		({1'b0, taken_q} + {1'b0, left_q}) <= 5'd13)
	// A stalled scale request holds
	`EDG_ASSERT_NEXT(a_s2_hold, valid_s2 && !scale_ready,
		valid_s2 && $stable(op_s2))

endmodule

// ----- sv/edg_scale.sv -----
// Multiply by ln2 and the output register of the deviate channel.
// Depends on edg_pkg and edg_dev_if.
module edg_scale import edg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       op_valid,
	input  edg_op_t    op,
	output logic       ready,
	edg_dev_if.source  deviates
);

	logic              valid_q;
	logic [DEV_W-1:0]  dev_q;
	logic [USED_W-1:0] used_q;

	logic [63:0]       frac_prod;
	logic [37:0]       whole_prod;
	logic [38:0]       dev_sum;

	assign ready = !valid_q || deviates.ready;

	// (whole + frac) * ln2, fraction product truncated, plus the direct addend
	assign frac_prod  = 64'(op.frac) * 64'(LN2_FIX);
	assign whole_prod = 38'(op.whole) * 38'(LN2_FIX);
	assign dev_sum    = 39'(whole_prod) + 39'(frac_prod[63:32]) + 39'(op.addend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && op_valid) begin
			dev_q  <= dev_sum[DEV_W-1:0];
			used_q <= op.used;
		end
	end

	assign deviates.valid      = valid_q;
	assign deviates.deviate    = dev_q;
	assign deviates.words_used = used_q;

endmodule

// ----- sv/exponential_deviate_generator_top.sv -----
// Unit-mean exponential deviate generator (Knuth, Algorithm S). It takes one
// 32-bit uniform word per cycle on uniforms while not stalled and returns
// deviates in unsigned 5.32 fixed point on deviates, each with the count of
// words it consumed: one word when the fraction left after the leading ones
// falls below ln2, otherwise k+1 words (3 to 12) for the minimum of k further
// words. The rate of one word per cycle is set by the sequencing stage, which
// updates the deviate state once per word; the multiply by ln2 sits in the
// output stage. Each deviate passes the input, scale request and output
// registers in turn; a waiting result stalls the input only once all three
// are occupied and the receiver still holds off.
// Depends on edg_pkg, edg_word_if, edg_dev_if, edg_front and edg_scale.
module exponential_deviate_generator_top import edg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	edg_word_if.sink  uniforms,
	edg_dev_if.source deviates
);

	logic    op_valid;
	logic    scale_ready;
	edg_op_t op;

	edg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.uniforms    (uniforms),
		.scale_ready (scale_ready),
		.op_valid    (op_valid),
		.op          (op)
	);

	edg_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op),
		.ready    (scale_ready),
		.deviates (deviates)
	);

endmodule

// ----- test/edg_deviate_checker.sv -----
// Checker for the exponential deviate generator: watches both channels,
// predicts each deviate from the accepted uniform words and compares.
// Depends on edg_pkg, edg_word_if and edg_dev_if.
`timescale 1ns / 100ps

module edg_deviate_checker import edg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	edg_word_if  uniforms,
	edg_dev_if   deviates,
	output int   errors,
	output int   pending,
	output int   words_seen,
	output int   deviates_seen,
	output int   minimum_draws,
	output int   longest_draw
);

	localparam int PRINT_CAP = 30;

	typedef enum logic [1:0] {
		AWAIT_FIRST = 2'd0,
		FOLD_MIN    = 2'd1
	} draw_phase_t;

	typedef struct packed {
		logic [DEV_W-1:0]  deviate;
		logic [USED_W-1:0] words_used;
	} deviate_t;

	// Deviates predicted but not yet seen on the output channel
	deviate_t awaited_deviates[$];

	// Predictor copy of the draw in progress
	draw_phase_t        phase;
	logic [ONES_W-1:0]  ones;
	logic [3:0]         left;
	logic [WORD_W-1:0]  run_min;
	logic [USED_W-1:0]  taken;

	// One line per mismatch, printing capped, counting not
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		if (errors <= PRINT_CAP)
			$display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// Fold one uniform word into the draw; done marks a finished deviate
	task automatic advance_draw(input logic [WORD_W-1:0] w, output bit done,
			output deviate_t res);
		int unsigned       j;
		int unsigned       k;
		bit                found;
		logic [63:0]       wide;
		logic [WORD_W-1:0] frac;
		done = 1'b0;
		res  = '0;
		if (phase != FOLD_MIN) begin
			// count leading ones, then drop them and the zero after them
			j = 0;
			while (j < 32 && w[31-j])
				j++;
			wide = {32'd0, w} << (j + 1);
			frac = wide[WORD_W-1:0];
			if (frac < LN2_FIX) begin
				wide = 64'(j) * 64'(LN2_FIX) + 64'(frac);
				res.deviate    = wide[DEV_W-1:0];
				res.words_used = USED_W'(1);
				done  = 1'b1;
				phase = AWAIT_FIRST;
			end else begin
				// least k with frac below the table entry
				k = K_FIRST;
				found = 1'b0;
				while (!found && k < Q_COUNT) begin
					if (frac < Q_TAB[k])
						found = 1'b1;
					else
						k++;
				end
				phase   = FOLD_MIN;
				ones    = ONES_W'(j);
				left    = 4'(k);
				run_min = '1;
				taken   = USED_W'(1);
			end
		end else begin
			if (w < run_min)
				run_min = w;
			taken = taken + 1'b1;
			if (left != 0)
				left = left - 1'b1;
			if (left == 0) begin
				// (j + V) * ln2, low fraction bits of the product dropped
				wide = 64'(ones) * 64'(LN2_FIX)
					+ ((64'(run_min) * 64'(LN2_FIX)) >> 32);
				res.deviate    = wide[DEV_W-1:0];
				res.words_used = taken;
				done  = 1'b1;
				phase = AWAIT_FIRST;
			end
		end
	endtask

	// Predict on accepted words, compare on accepted deviates
	always @(posedge clk or negedge arst_n) begin : watch
		bit       done;
		deviate_t res;
		deviate_t want;
		if (!arst_n) begin
			phase   = AWAIT_FIRST;
			ones    = '0;
			left    = '0;
			run_min = '0;
			taken   = '0;
			awaited_deviates.delete();
			pending = 0;
		end else begin
			if (uniforms.valid && uniforms.ready) begin
				words_seen++;
				advance_draw(uniforms.uniform_word, done, res);
				if (done)
					awaited_deviates.push_back(res);
			end
			if (deviates.valid && deviates.ready) begin
				deviates_seen++;
				if (deviates.words_used > 1)
					minimum_draws++;
				if (int'(deviates.words_used) > longest_draw)
					longest_draw = int'(deviates.words_used);
				if (awaited_deviates.size() == 0) begin
					report_mismatch("deviate with none awaited", 64'(deviates.deviate), 64'd0);
				end else begin
					want = awaited_deviates.pop_front();
					if (deviates.deviate !== want.deviate)
						report_mismatch("deviate", 64'(deviates.deviate), 64'(want.deviate));
					if (deviates.words_used !== want.words_used)
						report_mismatch("words_used", 64'(deviates.words_used),
							64'(want.words_used));
				end
			end
			pending = awaited_deviates.size();
		end
	end

endmodule

// ----- test/testbench.sv -----
// Top of the exponential deviate generator testbench: clock, reset, word
// stimulus, receiver stalls, watchdog and verdict.
// Depends on edg_pkg, both channel interfaces, the block and edg_deviate_checker.
`timescale 1ns / 100ps

module testbench;
	import edg_pkg::*;

	localparam int RANDOM_WORDS = 750;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES  = 150;

	logic clk;
	logic arst_n;

	int errors;
	int pending;
	int words_seen;
	int deviates_seen;
	int minimum_draws;
	int longest_draw;
	int idle_cycles;

	edg_word_if uniforms ();
	edg_dev_if  deviates ();

	exponential_deviate_generator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.uniforms (uniforms),
		.deviates (deviates)
	);

	edg_deviate_checker deviate_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.uniforms      (uniforms),
		.deviates      (deviates),
		.errors        (errors),
		.pending       (pending),
		.words_seen    (words_seen),
		.deviates_seen (deviates_seen),
		.minimum_draws (minimum_draws),
		.longest_draw  (longest_draw)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one word and hold it until the request is taken
	task automatic send_word(input logic [WORD_W-1:0] w);
		uniforms.valid        <= 1'b1;
		uniforms.uniform_word <= w;
		@(posedge clk);
		while (!uniforms.ready)
			@(posedge clk);
	endtask

	task automatic pause(input int cycles);
		uniforms.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Word that opens a draw: j leading ones, a zero, then a fraction that is
	// often close to one so the deeper table entries get hit
	function automatic logic [WORD_W-1:0] lead_word();
		int unsigned       j;
		logic [WORD_W-1:0] frac;
		case ($urandom_range(0, 19))
			0:       j = 32;
			1, 2, 3,
			4, 5, 6: j = $urandom_range(0, 31);
			default: j = $urandom_range(0, 3);
		endcase
		if (j == 32)
			return '1;
		if ($urandom_range(0, 1) == 0)
			frac = $urandom;
		else
			frac = ~($urandom >> $urandom_range(0, 31));
		return ~(32'hFFFF_FFFF >> j) | (frac >> (j + 1));
	endfunction

	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(0, 19))
			0:          return '0;
			1:          return '1;
			2:          return $urandom_range(0, 255);
			3:          return 32'h8000_0000 | $urandom_range(0, 15);
			4, 5, 6, 7: return $urandom;
			default:    return lead_word();
		endcase
	endfunction

	// Stimulus: reset, directed words, random bursts, drain, verdict
	initial begin : stimulus
		logic [WORD_W-1:0] directed [$];
		int sent;
		int burst;
		arst_n                <= 1'b0;
		uniforms.valid        <= 1'b0;
		uniforms.uniform_word <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		directed = '{
			// all ones: j of 32, nothing left of the fraction
			32'hFFFF_FFFF,
			// zero word, zero deviate
			32'h0000_0000,
			// fraction just under ln2
			32'h58B9_0BFB,
			// fraction exactly ln2, shortest minimum draw
			32'h58B9_0BFC, 32'hFFFF_FFFF, 32'h0000_0000,
			// 31 leading ones
			32'hFFFF_FFFE,
			// deepest reachable draw, eleven more words
			32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE,
			32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0001, 32'hDEAD_BEEF,
			32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
			// many leading ones, minimum of all ones: largest minimum-draw deviate
			32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hFFFF_FFFF
		};
		foreach (directed[i])
			send_word(directed[i]);
		pause(4);

		// Random bursts, some back to back
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && sent < RANDOM_WORDS; i++) begin
				send_word(random_word());
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 6));
		end
		uniforms.valid <= 1'b0;

		// Drain: the watchdog bounds this wait
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d uniform words and %0d deviates, %0d of them minimum draws.",
			words_seen, deviates_seen, minimum_draws);
		$display("Longest draw took %0d words; the receiver twice backed up the input.",
			longest_draw);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Receiver: random stall modes per segment, plus two long hold-offs
	initial begin : receiver
		int cyc;
		int hold_left;
		int seg_len;
		int mode;
		deviates.ready <= 1'b0;
		do
			@(posedge clk);
		while (!arst_n);
		cyc = 0;
		hold_left = 0;
		forever begin
			seg_len = $urandom_range(10, 80);
			mode    = $urandom_range(0, 3);
			repeat (seg_len) begin
				cyc++;
				if (hold_left == 0 && (cyc == 300 || cyc == 700))
					hold_left = HOLD_CYCLES;
				if (hold_left > 0) begin
					deviates.ready <= 1'b0;
					hold_left--;
				end else begin
					case (mode)
						0:       deviates.ready <= 1'b1;
						1:       deviates.ready <= ($urandom_range(0, 1) == 0);
						2:       deviates.ready <= ($urandom_range(0, 3) == 0);
						default: deviates.ready <= ($urandom_range(0, 3) != 0);
					endcase
				end
				@(posedge clk);
			end
		end
	end

	// Watchdog: too long with no request taken on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((uniforms.valid && uniforms.ready) || (deviates.valid && deviates.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no request taken for %0d cycles", IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end else begin
			idle_cycles <= 0;
		end
	end

endmodule
